FILE: hdl/cnft_pkg.sv
// types, constants and search helpers shared by the next cron match block
package cnft_pkg;

	localparam int unsigned MINS_PER_HOUR = 60;
	localparam int unsigned HOURS_PER_DAY = 24;
	localparam int unsigned DAYS_PER_WEEK = 7;
	localparam int unsigned MINS_PER_DAY  = MINS_PER_HOUR * HOURS_PER_DAY;
	localparam int unsigned MINS_PER_WEEK = MINS_PER_DAY * DAYS_PER_WEEK;

	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned WEEKDAY_W = 3;
	localparam int unsigned AHEAD_W  = 14;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 60;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MINUTE_MASK  = 2'd0,
		REG_HOUR_MASK    = 2'd1,
		REG_WEEKDAY_MASK = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [WEEKDAY_W-1:0] cur_weekday;
		logic [HOUR_W-1:0]    cur_hour;
		logic [MINUTE_W-1:0]  cur_minute;
	} query_t;

	typedef struct packed {
		logic [WEEKDAY_W-1:0] next_weekday;
		logic [HOUR_W-1:0]    next_hour;
		logic [MINUTE_W-1:0]  next_minute;
		logic [AHEAD_W-1:0]   minutes_ahead;
		logic                 no_match;
	} result_t;

	typedef struct packed {
		logic [MINS_PER_HOUR-1:0] minute_mask;
		logic [HOURS_PER_DAY-1:0] hour_mask;
		logic [DAYS_PER_WEEK-1:0] weekday_mask;
	} masks_t;

	// lowest set minute
	function automatic logic [MINUTE_W-1:0] low_minute(input logic [MINS_PER_HOUR-1:0] v);
		logic [MINUTE_W-1:0] r;
		r = '0;
		for (int i = MINS_PER_HOUR - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = MINUTE_W'(i);
			end
		end
		return r;
	endfunction

	// lowest set hour
	function automatic logic [HOUR_W-1:0] low_hour(input logic [HOURS_PER_DAY-1:0] v);
		logic [HOUR_W-1:0] r;
		r = '0;
		for (int i = HOURS_PER_DAY - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = HOUR_W'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: hdl/cnft_cfg.sv
// schedule mask registers and their write decode
module cnft_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [cnft_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cnft_pkg::CFG_DATA_W-1:0]    cfg_data,
	output cnft_pkg::masks_t                   masks
);

	cnft_pkg::masks_t masks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cnft_pkg::REG_MINUTE_MASK: begin
					masks_q.minute_mask <= cfg_data[cnft_pkg::MINS_PER_HOUR-1:0];
				end
				cnft_pkg::REG_HOUR_MASK: begin
					masks_q.hour_mask <= cfg_data[cnft_pkg::HOURS_PER_DAY-1:0];
				end
				cnft_pkg::REG_WEEKDAY_MASK: begin
					masks_q.weekday_mask <= cfg_data[cnft_pkg::DAYS_PER_WEEK-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign masks = masks_q;

endmodule

FILE: hdl/cnft_search.sv
// next matching minute search: minute, hour and weekday circular encodes
module cnft_search (
	input  cnft_pkg::query_t  query,
	input  cnft_pkg::masks_t  masks,
	output cnft_pkg::result_t result
);

	logic [cnft_pkg::WEEKDAY_W-1:0]     wd;
	logic [cnft_pkg::HOUR_W-1:0]        hr;
	logic [cnft_pkg::MINUTE_W-1:0]      mn;
	logic [cnft_pkg::MINS_PER_HOUR-1:0] min_above;
	logic [cnft_pkg::HOURS_PER_DAY-1:0] hour_above;
	logic [cnft_pkg::MINUTE_W-1:0]      min_first;
	logic [cnft_pkg::HOUR_W-1:0]        hour_first;
	logic                               empty;
	logic                               today;
	logic [cnft_pkg::WEEKDAY_W-1:0]     day_sel;
	logic [cnft_pkg::WEEKDAY_W:0]       day_off;
	logic [cnft_pkg::WEEKDAY_W:0]       day_idx;
	logic [cnft_pkg::HOUR_W-1:0]        hour_sel;
	logic [cnft_pkg::MINUTE_W-1:0]      min_sel;
	logic [15:0]                        ahead;

	always_comb begin
		// out-of-range time saturates
		wd = (query.cur_weekday > 3'd6) ? 3'd6 : query.cur_weekday;
		hr = (query.cur_hour > 5'd23) ? 5'd23 : query.cur_hour;
		mn = (query.cur_minute > 6'd59) ? 6'd59 : query.cur_minute;

		for (int i = 0; i < cnft_pkg::MINS_PER_HOUR; i++) begin
			min_above[i] = masks.minute_mask[i] && (cnft_pkg::MINUTE_W'(i) > mn);
		end
		for (int i = 0; i < cnft_pkg::HOURS_PER_DAY; i++) begin
			hour_above[i] = masks.hour_mask[i] && (cnft_pkg::HOUR_W'(i) > hr);
		end
		min_first  = cnft_pkg::low_minute(masks.minute_mask);
		hour_first = cnft_pkg::low_hour(masks.hour_mask);
		empty = !(|masks.minute_mask) || !(|masks.hour_mask) || !(|masks.weekday_mask);
		today = masks.weekday_mask[wd];

		// following days, a full week round onto the same weekday
		day_sel = wd;
		day_off = 4'd7;
		for (int k = cnft_pkg::DAYS_PER_WEEK; k >= 1; k--) begin
			day_idx = 4'(wd) + 4'(k);
			if (day_idx >= 4'd7) begin
				day_idx = day_idx - 4'd7;
			end
			if (masks.weekday_mask[day_idx[cnft_pkg::WEEKDAY_W-1:0]]) begin
				day_sel = day_idx[cnft_pkg::WEEKDAY_W-1:0];
				day_off = 4'(k);
			end
		end

		if (today && masks.hour_mask[hr] && (|min_above)) begin
			day_sel  = wd;
			day_off  = '0;
			hour_sel = hr;
			min_sel  = cnft_pkg::low_minute(min_above);
		end else if (today && (|hour_above)) begin
			day_sel  = wd;
			day_off  = '0;
			hour_sel = cnft_pkg::low_hour(hour_above);
			min_sel  = min_first;
		end else begin
			hour_sel = hour_first;
			min_sel  = min_first;
		end

		ahead = 16'(day_off) * 16'(cnft_pkg::MINS_PER_DAY)
			+ 16'(hour_sel) * 16'(cnft_pkg::MINS_PER_HOUR) + 16'(min_sel)
			- 16'(hr) * 16'(cnft_pkg::MINS_PER_HOUR) - 16'(mn);

		if (empty) begin
			result = '0;
			result.no_match = 1'b1;
		end else begin
			result.next_weekday  = day_sel;
			result.next_hour     = hour_sel;
			result.next_minute   = min_sel;
			result.minutes_ahead = ahead[cnft_pkg::AHEAD_W-1:0];
			result.no_match      = 1'b0;
		end
	end

endmodule

FILE: hdl/cron_next_fire_time.sv
// top level: next cron match time, query register, search and result register
// Each query beat (weekday, hour, minute) yields one result beat giving the
// next minute strictly after it whose weekday, hour and minute are all set in
// the three schedule masks, and how many minutes ahead it lies (1 to 10080).
// Query input register, combinational search, result register. A new query is
// taken every cycle unless query_stall holds it, so sustained rate is one
// query per cycle. An empty mask gives a result with no_match set and all
// other fields zero. Masks reset to all ones; the user must write them through
// the config port only while no query is in flight (the block does not check).
module cron_next_fire_time (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               query_valid,
	output logic                               query_stall,
	input  cnft_pkg::query_t                   query,
	output logic                               result_valid,
	input  logic                               result_stall,
	output cnft_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cnft_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cnft_pkg::CFG_DATA_W-1:0]    cfg_data
);

	cnft_pkg::masks_t  masks;
	cnft_pkg::query_t  query_s1;
	logic              valid_s1;
	cnft_pkg::result_t found;
	cnft_pkg::result_t result_s2;
	logic              valid_s2;
	logic              advance;

	assign cfg_ready = 1'b1;

	cnft_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.masks     (masks)
	);

	cnft_search u_search (
		.query  (query_s1),
		.masks  (masks),
		.result (found)
	);

	assign advance     = !valid_s2 || !result_stall;
	assign query_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!query_stall) begin
			valid_s1 <= query_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!query_stall && query_valid) begin
			query_s1 <= query;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= found;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTHESIS
	a_ahead_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.no_match |->
			result.minutes_ahead != '0 && result.minutes_ahead <= 14'd10080)
		else $error("minutes ahead out of range");

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.no_match |-> result.minutes_ahead == '0)
		else $error("no match beat carries a distance");

	a_minute_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.no_match |->
			result.next_minute <= 6'd59 && masks.minute_mask[result.next_minute])
		else $error("reported minute not in mask");

	a_hour_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.no_match |->
			result.next_hour <= 5'd23 && masks.hour_mask[result.next_hour])
		else $error("reported hour not in mask");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && result_stall |-> query_stall)
		else $error("query taken while both stages are held");
`endif

endmodule

FILE: tb/testbench.sv
// testbench for cron_next_fire_time: random and directed queries checked against a local search
`timescale 1ns / 100ps

module testbench;

	localparam logic [cnft_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned TIMEOUT_NS = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic query_valid = 1'b0;
	logic query_stall;
	cnft_pkg::query_t query = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	cnft_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [cnft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cnft_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	cnft_pkg::masks_t sched = '1;
	cnft_pkg::query_t pending_queries[$];
	cnft_pkg::result_t due_results[$];
	logic query_beat = 1'b0;
	logic result_beat = 1'b0;
	logic cfg_beat = 1'b0;
	logic query_on = 1'b0;
	int unsigned query_gap = 0;
	int unsigned result_wait = 0;
	logic steady_queries = 1'b0;
	logic steady_results = 1'b0;
	int unsigned failures = 0;

	cron_next_fire_time DUT (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.query(query),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// earliest allowed minute strictly after the query, wrapping round the week
	function automatic cnft_pkg::result_t next_fire(cnft_pkg::query_t q);
		int unsigned wd, hr, mn, now, t, d, h, m;
		cnft_pkg::result_t r;
		r = '0;
		wd = (q.cur_weekday > cnft_pkg::DAYS_PER_WEEK - 1)
			? cnft_pkg::DAYS_PER_WEEK - 1 : q.cur_weekday;
		hr = (q.cur_hour > cnft_pkg::HOURS_PER_DAY - 1)
			? cnft_pkg::HOURS_PER_DAY - 1 : q.cur_hour;
		mn = (q.cur_minute > cnft_pkg::MINS_PER_HOUR - 1)
			? cnft_pkg::MINS_PER_HOUR - 1 : q.cur_minute;
		if (sched.minute_mask == 0 || sched.hour_mask == 0 || sched.weekday_mask == 0) begin
			r.no_match = 1'b1;
			return r;
		end
		now = wd * cnft_pkg::MINS_PER_DAY + hr * cnft_pkg::MINS_PER_HOUR + mn;
		for (int unsigned k = 1; k <= cnft_pkg::MINS_PER_WEEK; k++) begin
			t = (now + k) % cnft_pkg::MINS_PER_WEEK;
			d = t / cnft_pkg::MINS_PER_DAY;
			h = (t % cnft_pkg::MINS_PER_DAY) / cnft_pkg::MINS_PER_HOUR;
			m = t % cnft_pkg::MINS_PER_HOUR;
			if (sched.weekday_mask[d] && sched.hour_mask[h] && sched.minute_mask[m]) begin
				r.next_weekday = cnft_pkg::WEEKDAY_W'(d);
				r.next_hour = cnft_pkg::HOUR_W'(h);
				r.next_minute = cnft_pkg::MINUTE_W'(m);
				r.minutes_ahead = cnft_pkg::AHEAD_W'(k);
				return r;
			end
		end
		r.no_match = 1'b1;
		return r;
	endfunction

	// query driver
	always @(negedge clk) begin
		if (query_beat) begin
			query_on = 1'b0;
			query_gap = steady_queries ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 39) == 0) steady_queries = !steady_queries;
		end
		if (!query_on) begin
			if (query_gap != 0) begin
				query_gap--;
			end else if (pending_queries.size() != 0) begin
				query <= pending_queries.pop_front();
				query_on = 1'b1;
			end
		end
		query_valid <= query_on;
	end

	// result back-pressure
	always @(negedge clk) begin
		if (result_beat) begin
			result_wait = steady_results ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 39) == 0) steady_results = !steady_results;
		end
		result_stall <= (result_wait != 0);
		if (result_wait != 0 && result_valid) result_wait--;
	end

	// monitor
	always @(posedge clk) begin
		cnft_pkg::result_t want;
		query_beat <= arst_n && query_valid && !query_stall;
		result_beat <= arst_n && result_valid && !result_stall;
		cfg_beat <= arst_n && cfg_valid && cfg_ready;
		if (arst_n && cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cnft_pkg::REG_MINUTE_MASK: begin
					sched.minute_mask = cfg_data[cnft_pkg::MINS_PER_HOUR-1:0];
				end
				cnft_pkg::REG_HOUR_MASK: begin
					sched.hour_mask = cfg_data[cnft_pkg::HOURS_PER_DAY-1:0];
				end
				cnft_pkg::REG_WEEKDAY_MASK: begin
					sched.weekday_mask = cfg_data[cnft_pkg::DAYS_PER_WEEK-1:0];
				end
				default: begin
				end
			endcase
		end
		if (arst_n && query_valid && !query_stall) due_results.push_back(next_fire(query));
		if (arst_n && result_valid && !result_stall) begin
			if (due_results.size() == 0) begin
				failures++;
				if (failures <= 10) $display("unexpected result beat %p", result);
			end else begin
				want = due_results.pop_front();
				if (result.next_weekday !== want.next_weekday
						|| result.next_hour !== want.next_hour
						|| result.next_minute !== want.next_minute
						|| result.minutes_ahead !== want.minutes_ahead
						|| result.no_match !== want.no_match) begin
					failures++;
					if (failures <= 10) begin
						$display("mismatch at %0t: expected %p, got %p", $realtime, want, result);
					end
				end
			end
		end
	end

	task automatic write_reg(logic [cnft_pkg::CFG_IDX_W-1:0] idx,
			logic [cnft_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_beat);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_masks(logic [cnft_pkg::CFG_DATA_W-1:0] mins,
			logic [cnft_pkg::CFG_DATA_W-1:0] hours, logic [cnft_pkg::CFG_DATA_W-1:0] days);
		write_reg(cnft_pkg::REG_MINUTE_MASK, mins);
		write_reg(cnft_pkg::REG_HOUR_MASK, hours);
		write_reg(cnft_pkg::REG_WEEKDAY_MASK, days);
	endtask

	task automatic push_query(logic [cnft_pkg::WEEKDAY_W-1:0] d, logic [cnft_pkg::HOUR_W-1:0] h,
			logic [cnft_pkg::MINUTE_W-1:0] m);
		pending_queries.push_back({d, h, m});
	endtask

	task automatic drain;
		while (pending_queries.size() != 0 || query_on || due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [cnft_pkg::CFG_DATA_W-1:0] draw_mask(int unsigned bits);
		logic [cnft_pkg::CFG_DATA_W-1:0] v;
		v = cnft_pkg::CFG_DATA_W'({$urandom, $urandom});
		case ($urandom_range(0, 13))
			0, 1: v = '1;
			2: v = '0;
			3, 4, 5: v = (v & ~((cnft_pkg::CFG_DATA_W'(1) << bits) - 1))
					| (cnft_pkg::CFG_DATA_W'(1) << $urandom_range(0, bits - 1));
			6, 7, 8: v = v & cnft_pkg::CFG_DATA_W'({$urandom, $urandom} & {$urandom, $urandom});
			default: begin
			end
		endcase
		return v;
	endfunction

	initial begin
		#TIMEOUT_NS;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset masks: every minute allowed, including wrap and saturating inputs
		push_query(0, 0, 0);
		push_query(6, 23, 59);
		push_query(7, 31, 63);
		push_query(7, 0, 0);
		push_query(0, 24, 0);
		push_query(0, 0, 60);
		push_query(2, 13, 47);
		drain;

		// one allowed minute in the week: same minute means a full week ahead
		set_masks(cnft_pkg::CFG_DATA_W'(1) << 30, cnft_pkg::CFG_DATA_W'(1) << 12,
			cnft_pkg::CFG_DATA_W'(1) << 3);
		push_query(3, 12, 30);
		push_query(3, 12, 29);
		push_query(3, 12, 31);
		push_query(4, 0, 0);
		drain;
		write_reg(REG_UNUSED, '0);
		push_query(3, 12, 29);
		drain;

		// edge bits of each mask
		set_masks((cnft_pkg::CFG_DATA_W'(1) << 59) | 1, (cnft_pkg::CFG_DATA_W'(1) << 23) | 1,
			(cnft_pkg::CFG_DATA_W'(1) << 6) | 1);
		push_query(6, 23, 59);
		push_query(0, 0, 0);
		drain;

		// empty masks, including ones with only bits above the field
		write_reg(cnft_pkg::REG_MINUTE_MASK, '0);
		push_query(1, 1, 1);
		drain;
		set_masks('1, ~cnft_pkg::CFG_DATA_W'(24'hFFFFFF), '1);
		push_query(5, 10, 20);
		drain;
		set_masks('1, '1, ~cnft_pkg::CFG_DATA_W'(7'h7F));
		push_query(5, 10, 20);
		drain;

		for (int p = 0; p < 8; p++) begin
			set_masks(draw_mask(cnft_pkg::MINS_PER_HOUR), draw_mask(cnft_pkg::HOURS_PER_DAY),
				draw_mask(cnft_pkg::DAYS_PER_WEEK));
			repeat (50) begin
				if ($urandom_range(0, 4) == 0) begin
					push_query(cnft_pkg::WEEKDAY_W'($urandom_range(0, 7)),
						cnft_pkg::HOUR_W'($urandom_range(0, 31)),
						cnft_pkg::MINUTE_W'($urandom_range(0, 63)));
				end else begin
					push_query(cnft_pkg::WEEKDAY_W'($urandom_range(0, 6)),
						cnft_pkg::HOUR_W'($urandom_range(0, 23)),
						cnft_pkg::MINUTE_W'($urandom_range(0, 59)));
				end
			end
			drain;
		end

		if (due_results.size() != 0) failures++;
		if (failures == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
